// ===== sv/bnr_pkg.sv =====
// shared types and constants for the batch norm / rectifier pipeline
// no dependencies; used by bnr_div, bnr_sqrt and batch_norm_relu_inference
`timescale 1ns / 1ps
package bnr_pkg;

   // fraction bits of the inverse square root
   localparam int RSQ_FRAC = 20;
   // the scaled product magnitude is capped at 2**Q_CAP_EXP
   localparam int Q_CAP_EXP = 40;
   // largest result value
   localparam logic [22:0] OUT_MAX = 23'h7FFFFF;
   // width of the split used by the final product
   localparam int SPLIT_W = 24;

   // per-item payload that rides along with the root pipelines
   typedef struct packed {
      logic               neg;
      logic [47:0]        mag;
      logic signed [23:0] beta;
   } side_type;

endpackage

// ===== sv/bnr_div.sv =====
// pipelined restoring divider, one quotient bit per stage: q = 2**(QW-1) / v
// depends on bnr_pkg
`timescale 1ns / 1ps
module bnr_div #(
   parameter int QW = 59
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [23:0]       in_v,
   input  bnr_pkg::side_type in_side,
   output logic              out_vld,
   output logic [QW-1:0]     out_q,
   output bnr_pkg::side_type out_side
);
   import bnr_pkg::*;

   logic          vld_ff  [QW];
   logic [23:0]   rem_ff  [QW];
   logic [23:0]   v_ff    [QW];
   logic [QW-1:0] q_ff    [QW];
   side_type      side_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int B = QW - 1 - s;
      logic          prev_vld;
      logic [23:0]   prev_rem;
      logic [23:0]   prev_v;
      logic [QW-1:0] prev_q;
      side_type      prev_side;
      logic [24:0]   shifted;
      logic          ge;
      logic [23:0]   rem_in;
      logic [QW-1:0] q_in;

      // previous stage or the pipeline input
      if (s == 0) begin : g_first
         assign prev_vld  = in_vld;
         assign prev_rem  = '0;
         assign prev_v    = in_v;
         assign prev_q    = '0;
         assign prev_side = in_side;
         assign shifted   = 25'd1;
      end else begin : g_next
         assign prev_vld  = vld_ff[s-1];
         assign prev_rem  = rem_ff[s-1];
         assign prev_v    = v_ff[s-1];
         assign prev_q    = q_ff[s-1];
         assign prev_side = side_ff[s-1];
         assign shifted   = {prev_rem, 1'b0};
      end

      // trial subtract
      always_comb begin
         ge     = shifted >= {1'b0, prev_v};
         rem_in = ge ? 24'(shifted - {1'b0, prev_v}) : shifted[23:0];
         q_in   = prev_q;
         q_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= prev_vld;
         end
         if (en) begin
            rem_ff[s]  <= rem_in;
            v_ff[s]    <= prev_v;
            q_ff[s]    <= q_in;
            side_ff[s] <= prev_side;
         end
      end
   end

   assign out_vld  = vld_ff[QW-1];
   assign out_q    = q_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule

// ===== sv/bnr_sqrt.sv =====
// pipelined digit-by-digit integer square root, one root bit per stage
// depends on bnr_pkg
`timescale 1ns / 1ps
module bnr_sqrt #(
   parameter int QW = 59,
   parameter int MB = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [QW-1:0]     in_n,
   input  bnr_pkg::side_type in_side,
   output logic              out_vld,
   output logic [MB-1:0]     out_m,
   output bnr_pkg::side_type out_side
);
   import bnr_pkg::*;

   localparam int DW = 2 * MB + 1;

   logic          vld_ff  [MB];
   logic [QW-1:0] rem_ff  [MB];
   logic [MB-1:0] m_ff    [MB];
   side_type      side_ff [MB];

   for (genvar s = 0; s < MB; s++) begin : g_stage
      localparam int K = MB - 1 - s;
      logic          prev_vld;
      logic [QW-1:0] prev_rem;
      logic [MB-1:0] prev_m;
      side_type      prev_side;
      logic [DW-1:0] delta;
      logic [DW-1:0] rem_ext;
      logic          ge;
      logic [QW-1:0] rem_in;
      logic [MB-1:0] m_in;

      if (s == 0) begin : g_first
         assign prev_vld  = in_vld;
         assign prev_rem  = in_n;
         assign prev_m    = '0;
         assign prev_side = in_side;
      end else begin : g_next
         assign prev_vld  = vld_ff[s-1];
         assign prev_rem  = rem_ff[s-1];
         assign prev_m    = m_ff[s-1];
         assign prev_side = side_ff[s-1];
      end

      // (m + 2**k)**2 - m**2 against the remaining radicand
      always_comb begin
         delta   = (DW'(prev_m) << (K + 1)) + (DW'(1) << (2 * K));
         rem_ext = DW'(prev_rem);
         ge      = rem_ext >= delta;
         rem_in  = ge ? QW'(rem_ext - delta) : prev_rem;
         m_in    = prev_m;
         m_in[K] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= prev_vld;
         end
         if (en) begin
            rem_ff[s]  <= rem_in;
            m_ff[s]    <= m_in;
            side_ff[s] <= prev_side;
         end
      end
   end

   assign out_vld  = vld_ff[MB-1];
   assign out_m    = m_ff[MB-1];
   assign out_side = side_ff[MB-1];

endmodule

// ===== sv/batch_norm_relu_inference.sv =====
// Batch normalization (inference) with rectifier, fully pipelined. One request
// is accepted per clock while the pipe advances. The pipe holds 2 front
// stages, QW (59 at 16 fraction bits) divider stages, MB (30) root stages and
// 3 back stages; the long restoring divider and square-root chains, one bit
// per stage, make up most of it. The whole pipe advances together whenever
// the result register is empty or being taken.
// depends on bnr_pkg, bnr_div, bnr_sqrt
`timescale 1ns / 1ps
module batch_norm_relu_inference #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data,     // epsilon_offset
   input  logic         req_tvalid,
   output logic         req_tready,
   // activation, channel_mean, channel_variance, channel_scale, channel_shift
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata     // normalized_output, one zero pad bit
);
   import bnr_pkg::*;

   localparam int NUM_EXP = 2 * RSQ_FRAC + FRAC_BITS + 2;
   localparam int QW      = NUM_EXP + 1;
   localparam int MB      = NUM_EXP / 2 + 1;
   localparam int SH      = RSQ_FRAC + FRAC_BITS;
   localparam int PW      = SPLIT_W + MB;
   localparam int SW      = PW + 2;

   logic en;
   logic [7:0] eps_ff;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 8'd1;
      end else if (csr_valid) begin
         eps_ff <= csr_data;
      end
   end

   // the whole pipe moves when the output slot is free or being taken
   logic rsp_vld_ff;
   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   // front stage: difference and denominator
   logic signed [23:0] x_w, mean_w, gamma_w, beta_w;
   logic [22:0]        var_w;
   logic signed [24:0] d_in;
   logic [23:0]        v_sum, v_in;
   always_comb begin
      x_w     = req_tdata[23:0];
      mean_w  = req_tdata[47:24];
      var_w   = req_tdata[70:48];
      gamma_w = req_tdata[94:71];
      beta_w  = req_tdata[118:95];
      d_in    = 25'(x_w) - 25'(mean_w);
      v_sum   = 24'(var_w) + 24'(eps_ff);
      v_in    = (v_sum == '0) ? 24'd1 : v_sum;
   end

   logic               f1_vld_ff;
   logic signed [24:0] f1_d_ff;
   logic signed [23:0] f1_g_ff, f1_beta_ff;
   logic [23:0]        f1_v_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else if (en) begin
         f1_vld_ff <= req_tvalid;
      end
      if (en) begin
         f1_d_ff    <= d_in;
         f1_g_ff    <= gamma_w;
         f1_beta_ff <= beta_w;
         f1_v_ff    <= v_in;
      end
   end

   // magnitude product of difference and scale
   logic [24:0] abs_d;
   logic [23:0] abs_g;
   logic [48:0] mag_w;
   side_type    side_in;
   always_comb begin
      abs_d = f1_d_ff[24] ? 25'(-f1_d_ff) : 25'(f1_d_ff);
      abs_g = f1_g_ff[23] ? 24'(-f1_g_ff) : 24'(f1_g_ff);
      mag_w = 49'(abs_d) * 49'(abs_g);
      side_in.neg  = f1_d_ff[24] ^ f1_g_ff[23];
      side_in.mag  = mag_w[47:0];
      side_in.beta = f1_beta_ff;
   end

   logic        f2_vld_ff;
   logic [23:0] f2_v_ff;
   side_type    f2_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         f2_vld_ff <= 1'b0;
      end else if (en) begin
         f2_vld_ff <= f1_vld_ff;
      end
      if (en) begin
         f2_v_ff    <= f1_v_ff;
         f2_side_ff <= side_in;
      end
   end

   // quotient then root
   logic          div_vld;
   logic [QW-1:0] div_q;
   side_type      div_side;
   bnr_div #(.QW(QW)) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (f2_vld_ff),
      .in_v    (f2_v_ff),
      .in_side (f2_side_ff),
      .out_vld (div_vld),
      .out_q   (div_q),
      .out_side(div_side)
   );

   logic          rt_vld;
   logic [MB-1:0] rt_m;
   side_type      rt_side;
   bnr_sqrt #(.QW(QW), .MB(MB)) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (div_vld),
      .in_n    (div_q),
      .in_side (div_side),
      .out_vld (rt_vld),
      .out_m   (rt_m),
      .out_side(rt_side)
   );

   // split product with the rounded inverse root
   logic [MB-1:0] r_w;
   logic [PW-1:0] lo_w, hi_w;
   always_comb begin
      r_w  = MB'((MB + 1)'(rt_m) + (MB + 1)'(1) >> 1);
      lo_w = PW'(rt_side.mag[SPLIT_W-1:0]) * PW'(r_w);
      hi_w = PW'(rt_side.mag[47:SPLIT_W]) * PW'(r_w);
   end

   logic          p1_vld_ff;
   logic [PW-1:0] p1_lo_ff, p1_hi_ff;
   logic          p1_neg_ff;
   logic signed [23:0] p1_beta_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= rt_vld;
      end
      if (en) begin
         p1_lo_ff   <= lo_w;
         p1_hi_ff   <= hi_w;
         p1_neg_ff  <= rt_side.neg;
         p1_beta_ff <= rt_side.beta;
      end
   end

   // rounding, scaling shift and cap
   logic [SW-1:0]   lo_r, sum_w, q_w;
   logic [Q_CAP_EXP:0] qc_w;
   always_comb begin
      lo_r  = SW'(p1_lo_ff) + (SW'(1) << (SH - 1));
      sum_w = SW'(p1_hi_ff) + (lo_r >> SPLIT_W);
      q_w   = sum_w >> (SH - SPLIT_W);
      qc_w  = (q_w > (SW'(1) << Q_CAP_EXP)) ? ((Q_CAP_EXP + 1)'(1) << Q_CAP_EXP)
                                            : q_w[Q_CAP_EXP:0];
   end

   logic               p2_vld_ff;
   logic [Q_CAP_EXP:0] p2_q_ff;
   logic               p2_neg_ff;
   logic signed [23:0] p2_beta_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (en) begin
         p2_vld_ff <= p1_vld_ff;
      end
      if (en) begin
         p2_q_ff    <= qc_w;
         p2_neg_ff  <= p1_neg_ff;
         p2_beta_ff <= p1_beta_ff;
      end
   end

   // sign, bias and clamp into the result register
   logic signed [Q_CAP_EXP+2:0] sq_w, y_w;
   logic [22:0] res_w;
   always_comb begin
      sq_w = p2_neg_ff ? -$signed((Q_CAP_EXP + 3)'(p2_q_ff))
                       : $signed((Q_CAP_EXP + 3)'(p2_q_ff));
      y_w  = sq_w + (Q_CAP_EXP + 3)'(p2_beta_ff);
      if (y_w < 0) begin
         res_w = '0;
      end else if (y_w > $signed((Q_CAP_EXP + 3)'(OUT_MAX))) begin
         res_w = OUT_MAX;
      end else begin
         res_w = y_w[22:0];
      end
   end

   logic [22:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= p2_vld_ff;
      end
      if (en) begin
         rsp_data_ff <= res_w;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // a held result does not change while the consumer stalls
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // request side stalls exactly when the result slot is full and stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready out of step with result stall");

endmodule
